// ===== src/olt_pkg.sv =====
// Shared types, constants and helpers for the order lifecycle table.
package olt_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int QTY_BITS    = 20;
  localparam int SLOT_BITS   = $clog2(TABLE_DEPTH);

  typedef enum logic [1:0] {
    OP_PLACE  = 2'd0,
    OP_CANCEL = 2'd1,
    OP_FILL   = 2'd2,
    OP_LOOKUP = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ERR_OK         = 2'd0,
    ERR_NOT_FOUND  = 2'd1,
    ERR_TABLE_FULL = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    ST_NEW       = 2'd0,
    ST_PARTIAL   = 2'd1,
    ST_FILLED    = 2'd2,
    ST_CANCELLED = 2'd3
  } ord_state_t;

  typedef struct packed {
    op_t         opcode;
    logic [31:0] order_id;
    logic        side_in;
    logic [31:0] price_in;
    logic [19:0] amount_in;
  } olt_in_t;

  typedef struct packed {
    logic [31:0] result_id;
    err_t        error_code;
    ord_state_t  order_state;
    logic        side_out;
    logic [31:0] price_out;
    logic [19:0] quantity_out;
    logic [19:0] filled_out;
  } olt_out_t;

  typedef struct packed {
    logic [31:0]         tag;
    logic                side;
    logic [31:0]         price;
    logic [QTY_BITS-1:0] quantity;
    logic [QTY_BITS-1:0] filled;
    logic                partial;
  } olt_entry_t;

  // Table updates and the result for one transaction.
  typedef struct packed {
    logic       wr_en;
    logic       live_set;
    logic       live_clr;
    logic       id_inc;
    olt_entry_t wr_entry;
    olt_out_t   rsp;
  } olt_upd_t;

  function automatic logic [SLOT_BITS-1:0] slot_of(input logic [31:0] id);
    return SLOT_BITS'(id % TABLE_DEPTH);
  endfunction

endpackage

// ===== src/olt_slot_ram.sv =====
// Slot entry memory with registered read and same-edge write bypass.
module olt_slot_ram
  import olt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rd_en,
  input  logic [SLOT_BITS-1:0] rd_addr,
  input  logic                 wr_en,
  input  logic [SLOT_BITS-1:0] wr_addr,
  input  olt_entry_t           wr_entry,
  output olt_entry_t           rd_entry
);

  olt_entry_t mem [TABLE_DEPTH];
  olt_entry_t rd_q;
  olt_entry_t byp_entry;
  logic       byp;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q      <= mem[rd_addr];
      byp_entry <= wr_entry;
    end
  end

  // A write landing on the same edge as the read wins over the stale array data.
  always_ff @(posedge clk) begin
    if (rst) begin
      byp <= 1'b0;
    end else if (rd_en) begin
      byp <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_entry = byp ? byp_entry : rd_q;

endmodule

// ===== src/olt_exec.sv =====
// Per-transaction operation logic: decides table updates and the result.
module olt_exec
  import olt_pkg::*;
(
  input  olt_in_t     req,
  input  logic [31:0] nid,
  input  logic        live,
  input  olt_entry_t  entry,
  output olt_upd_t    upd
);

  logic [QTY_BITS-1:0] amount;
  logic [QTY_BITS-1:0] rem;
  logic [QTY_BITS-1:0] inc;
  logic [QTY_BITS-1:0] filled_new;
  logic                hit;

  assign amount     = QTY_BITS'(req.amount_in);
  assign rem        = (entry.quantity > entry.filled) ? entry.quantity - entry.filled : '0;
  assign inc        = (amount < rem) ? amount : rem;
  assign filled_new = entry.filled + inc;
  assign hit        = live && (entry.tag == req.order_id);

  always_comb begin
    upd                  = '0;
    upd.wr_entry         = entry;
    upd.rsp.result_id    = req.order_id;
    upd.rsp.error_code   = ERR_OK;
    upd.rsp.order_state  = ST_NEW;
    upd.rsp.side_out     = entry.side;
    upd.rsp.price_out    = entry.price;
    upd.rsp.quantity_out = 20'(entry.quantity);
    upd.rsp.filled_out   = 20'(entry.filled);
    if (req.opcode == OP_PLACE) begin
      upd.rsp.result_id = nid;
      if (live) begin
        upd.rsp.error_code   = ERR_TABLE_FULL;
        upd.rsp.side_out     = 1'b0;
        upd.rsp.price_out    = '0;
        upd.rsp.quantity_out = '0;
        upd.rsp.filled_out   = '0;
      end else begin
        upd.wr_en             = 1'b1;
        upd.live_set          = 1'b1;
        upd.id_inc            = 1'b1;
        upd.wr_entry.tag      = nid;
        upd.wr_entry.side     = req.side_in;
        upd.wr_entry.price    = req.price_in;
        upd.wr_entry.quantity = amount;
        upd.wr_entry.filled   = '0;
        upd.wr_entry.partial  = 1'b0;
        upd.rsp.side_out      = req.side_in;
        upd.rsp.price_out     = req.price_in;
        upd.rsp.quantity_out  = 20'(amount);
        upd.rsp.filled_out    = '0;
      end
    end else if (!hit) begin
      upd.rsp.error_code   = ERR_NOT_FOUND;
      upd.rsp.side_out     = 1'b0;
      upd.rsp.price_out    = '0;
      upd.rsp.quantity_out = '0;
      upd.rsp.filled_out   = '0;
    end else begin
      case (req.opcode)
        OP_CANCEL: begin
          upd.live_clr        = 1'b1;
          upd.rsp.order_state = ST_CANCELLED;
        end
        OP_FILL: begin
          upd.wr_en               = 1'b1;
          upd.wr_entry.filled     = filled_new;
          upd.rsp.filled_out      = 20'(filled_new);
          if (filled_new >= entry.quantity) begin
            upd.live_clr        = 1'b1;
            upd.rsp.order_state = ST_FILLED;
          end else begin
            upd.wr_entry.partial = 1'b1;
            upd.rsp.order_state  = ST_PARTIAL;
          end
        end
        default: begin
          upd.rsp.order_state = entry.partial ? ST_PARTIAL : ST_NEW;
        end
      endcase
    end
  end

endmodule

// ===== src/order_lifecycle_table_top.sv =====
// Order lifecycle table: place, cancel, fill and lookup on a slot-indexed order table.
//
// Requests enter on req/req_valid/req_ready and results leave on rsp/rsp_valid/rsp_ready;
// each request transaction yields exactly one result transaction, in order.
// Place takes the next 32-bit id and claims slot (id mod TABLE_DEPTH); cancel, fill
// and lookup name an id and report not_found when its slot is free or holds another id.
// A request is registered into the work stage when accepted and moves into the result
// register once that register is free or its result is taken.
// Throughput: one transaction per cycle unless the receiver stalls. The entry memory is read
// at the accept edge and written when the transaction moves into the result register; a write
// and a read of the same slot at one edge are bypassed, so back-to-back hits on a slot are exact.
// Reset clears the id counter, every slot's live bit and both pipeline valids at once;
// no clearing pass runs and requests are taken in the first cycle after reset.
// When the receiver stalls, the result register holds, the work stage holds behind it,
// and req_ready drops once both are occupied; nothing is lost or replayed.
module order_lifecycle_table_top
  import olt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  olt_in_t  req,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output olt_out_t rsp
);

  logic [31:0]            next_order_id;
  logic [31:0]            next_order_id_next;
  logic [TABLE_DEPTH-1:0] live;
  logic                   s1_valid;
  olt_in_t                s1_req;
  logic                   s1_advance;
  logic                   s1_fire;
  logic                   req_fire;
  logic [SLOT_BITS-1:0]   s1_slot;
  logic [SLOT_BITS-1:0]   rd_slot;
  olt_entry_t             entry;
  olt_upd_t               upd;

  assign s1_advance = !rsp_valid || rsp_ready;
  assign s1_fire    = s1_valid && s1_advance;
  assign req_ready  = !s1_valid || s1_advance;
  assign req_fire   = req_valid && req_ready;

  assign next_order_id_next = next_order_id + 32'(s1_fire && upd.id_inc);

  assign s1_slot = (s1_req.opcode == OP_PLACE) ? slot_of(next_order_id)
                                               : slot_of(s1_req.order_id);
  // A place reads the slot of the id it will get once the transaction ahead retires.
  assign rd_slot = (req.opcode == OP_PLACE) ? slot_of(next_order_id_next)
                                            : slot_of(req.order_id);

  olt_slot_ram u_ram (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (req_fire),
    .rd_addr  (rd_slot),
    .wr_en    (s1_fire && upd.wr_en),
    .wr_addr  (s1_slot),
    .wr_entry (upd.wr_entry),
    .rd_entry (entry)
  );

  olt_exec u_exec (
    .req   (s1_req),
    .nid   (next_order_id),
    .live  (live[s1_slot]),
    .entry (entry),
    .upd   (upd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      next_order_id <= '0;
      live          <= '0;
      s1_valid      <= 1'b0;
      rsp_valid     <= 1'b0;
    end else begin
      next_order_id <= next_order_id_next;
      if (s1_fire && upd.live_set) begin
        live[s1_slot] <= 1'b1;
      end else if (s1_fire && upd.live_clr) begin
        live[s1_slot] <= 1'b0;
      end
      if (req_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      s1_req <= req;
    end
    if (s1_fire) begin
      rsp <= upd.rsp;
    end
  end

  a_id_advance: assert property (@(posedge clk) disable iff (rst)
    s1_fire && upd.id_inc |=> next_order_id == $past(next_order_id) + 32'd1)
    else $error("order id did not advance after a successful place");

  a_id_hold: assert property (@(posedge clk) disable iff (rst)
    !(s1_fire && upd.id_inc) |=> next_order_id == $past(next_order_id))
    else $error("order id moved without a successful place");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.error_code != ERR_OK |->
      rsp.price_out == 32'd0 && rsp.quantity_out == 20'd0 && rsp.filled_out == 20'd0)
    else $error("error result carries order data");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.error_code == ERR_OK && rsp.order_state == ST_FILLED |->
      rsp.filled_out == rsp.quantity_out)
    else $error("filled result does not match the order quantity");

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the order lifecycle table: directed and random traffic.
module tb_top
  import olt_pkg::*;
();

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int NUM_PHASES   = 15;
  localparam int BATCH_ITEMS  = 123;
  localparam int LONG_HOLD    = 120;

  logic     clk;
  logic     rst       = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_ready;
  olt_in_t  req       = '0;
  logic     rsp_valid;
  logic     rsp_ready = 1'b0;
  olt_out_t rsp;

  order_lifecycle_table_top dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // Mirror of the order book, updated at each accepted request.
  logic [31:0] book_next_id;
  logic        book_live  [TABLE_DEPTH];
  olt_entry_t  book_entry [TABLE_DEPTH];

  olt_in_t  pending_orders [$];
  olt_out_t expected_rsp   [$];
  olt_out_t predicted;
  olt_out_t wanted;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_requests  = 0;
  int hold_served    = 0;
  int hold_left      = 0;
  int errors         = 0;
  int checked        = 0;
  int cycles         = 0;
  int op_count  [4];
  int err_count [3];

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic olt_out_t apply_order_op(olt_in_t t);
    olt_out_t            r;
    int                  s;
    logic [QTY_BITS-1:0] remain;
    logic [QTY_BITS-1:0] add;
    r = '0;
    if (t.opcode == OP_PLACE) begin
      s = int'(book_next_id % TABLE_DEPTH);
      r.result_id = book_next_id;
      if (book_live[s]) begin
        r.error_code = ERR_TABLE_FULL;
      end else begin
        book_live[s]           = 1'b1;
        book_entry[s].tag      = book_next_id;
        book_entry[s].side     = t.side_in;
        book_entry[s].price    = t.price_in;
        book_entry[s].quantity = t.amount_in;
        book_entry[s].filled   = '0;
        book_entry[s].partial  = 1'b0;
        book_next_id           = book_next_id + 32'd1;
        r.error_code   = ERR_OK;
        r.order_state  = ST_NEW;
        r.side_out     = t.side_in;
        r.price_out    = t.price_in;
        r.quantity_out = t.amount_in;
      end
    end else begin
      s = int'(t.order_id % TABLE_DEPTH);
      r.result_id = t.order_id;
      if (!book_live[s] || book_entry[s].tag != t.order_id) begin
        r.error_code = ERR_NOT_FOUND;
      end else begin
        case (t.opcode)
          OP_CANCEL: begin
            book_live[s]  = 1'b0;
            r.order_state = ST_CANCELLED;
          end
          OP_FILL: begin
            remain = (book_entry[s].quantity > book_entry[s].filled) ?
                     book_entry[s].quantity - book_entry[s].filled : '0;
            add = (t.amount_in < remain) ? t.amount_in : remain;
            book_entry[s].filled = book_entry[s].filled + add;
            if (book_entry[s].filled >= book_entry[s].quantity) begin
              book_live[s]  = 1'b0;
              r.order_state = ST_FILLED;
            end else begin
              book_entry[s].partial = 1'b1;
              r.order_state         = ST_PARTIAL;
            end
          end
          default: begin
            r.order_state = book_entry[s].partial ? ST_PARTIAL : ST_NEW;
          end
        endcase
        r.error_code   = ERR_OK;
        r.side_out     = book_entry[s].side;
        r.price_out    = book_entry[s].price;
        r.quantity_out = book_entry[s].quantity;
        r.filled_out   = book_entry[s].filled;
      end
    end
    return r;
  endfunction

  function automatic olt_in_t order_item(op_t op, logic [31:0] id, logic side,
                                         logic [31:0] price, logic [19:0] amount);
    olt_in_t t;
    t.opcode    = op;
    t.order_id  = id;
    t.side_in   = side;
    t.price_in  = price;
    t.amount_in = amount;
    return t;
  endfunction

  task automatic check_field(string field, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want_v, got_v);
      errors++;
    end
  endtask

  // Request driver: predict on accept, hold while stalled, then offer the next item.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        predicted = apply_order_op(req);
        expected_rsp.push_back(predicted);
        op_count[int'(req.opcode)]++;
        err_count[int'(predicted.error_code)]++;
      end
      if (req_valid && !req_ready) begin
        req_valid <= 1'b1;
      end else if (pending_orders.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        req       <= pending_orders.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_rsp.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual id %0h err %0d",
                   $time, rsp.result_id, rsp.error_code);
          errors++;
        end else begin
          wanted = expected_rsp.pop_front();
          checked++;
          check_field("result_id", wanted.result_id, rsp.result_id);
          check_field("error_code", 32'(wanted.error_code), 32'(rsp.error_code));
          check_field("order_state", 32'(wanted.order_state), 32'(rsp.order_state));
          check_field("side_out", 32'(wanted.side_out), 32'(rsp.side_out));
          check_field("price_out", wanted.price_out, rsp.price_out);
          check_field("quantity_out", 32'(wanted.quantity_out), 32'(rsp.quantity_out));
          check_field("filled_out", 32'(wanted.filled_out), 32'(rsp.filled_out));
        end
      end
      rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Long receiver hold-off, started on request.
  always @(posedge clk) begin
    if (rst) begin
      hold_left   <= 0;
      hold_served <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      hold_left   <= LONG_HOLD;
      hold_served <= hold_served + 1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic wait_until_drained();
    while (pending_orders.size() > 0 || req_valid || expected_rsp.size() > 0)
      @(negedge clk);
  endtask

  // Mostly well-formed traffic on ids believed live, plus stale and random ids.
  task automatic queue_random_batch(int n, bit place_heavy);
    logic [31:0] ids [$];
    logic [31:0] guess_id;
    logic [31:0] pick;
    olt_in_t     t;
    int          roll;
    int          idx;
    int          span;
    for (int i = 0; i < TABLE_DEPTH; i++)
      if (book_live[i]) ids.push_back(book_entry[i].tag);
    guess_id = book_next_id;
    for (int i = 0; i < n; i++) begin
      t = order_item(OP_LOOKUP, $urandom, 1'($urandom_range(1)), $urandom, 20'($urandom));
      idx = 0;
      if (ids.size() == 0) begin
        pick = guess_id;
      end else begin
        span = (ids.size() > 16 && $urandom_range(1)) ? 16 : ids.size();
        idx  = ids.size() - 1 - $urandom_range(span - 1);
        pick = ids[idx];
      end
      roll = $urandom_range(99);
      if (roll < (place_heavy ? 65 : 30)) begin
        t.opcode = OP_PLACE;
        case ($urandom_range(9))
          0: t.amount_in = '0;
          1: t.amount_in = 20'($urandom);
          default: t.amount_in = 20'($urandom_range(1, 40));
        endcase
        ids.push_back(guess_id);
        guess_id = guess_id + 32'd1;
        if (ids.size() > 300) void'(ids.pop_front());
      end else if (roll < 88) begin
        t.order_id = pick;
        roll = $urandom_range(99);
        if (roll < 20) begin
          t.opcode = OP_CANCEL;
          if (ids.size() > 0) ids.delete(idx);
        end else if (roll < 75) begin
          t.opcode = OP_FILL;
          case ($urandom_range(9))
            0: t.amount_in = '0;
            1, 2: t.amount_in = 20'($urandom);
            default: t.amount_in = 20'($urandom_range(1, 15));
          endcase
        end else begin
          t.opcode = OP_LOOKUP;
        end
      end else begin
        t.opcode = op_t'($urandom_range(1, 3));
        case ($urandom_range(2))
          0: t.order_id = pick + 32'(TABLE_DEPTH) * 32'($urandom_range(1, 100000));
          1: t.order_id = guess_id + 32'($urandom_range(0, 3));
          default: t.order_id = t.order_id;
        endcase
      end
      pending_orders.push_back(t);
    end
  endtask

  initial begin
    book_next_id = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      book_live[i]  = 1'b0;
      book_entry[i] = '0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: edges of the fields and the corner cases of the order lifecycle.
    pending_orders.push_back(order_item(OP_LOOKUP, 32'd0, 1'b0, 32'd0, 20'd0));
    pending_orders.push_back(order_item(OP_PLACE, 32'hFFFF_FFFF, 1'b0, 32'd0, 20'd0));
    pending_orders.push_back(order_item(OP_LOOKUP, 32'd0, 1'b1, 32'd5, 20'd3));
    pending_orders.push_back(order_item(OP_FILL, 32'd0, 1'b0, 32'd0, 20'd0));
    pending_orders.push_back(order_item(OP_LOOKUP, 32'd0, 1'b0, 32'd0, 20'd0));
    pending_orders.push_back(order_item(OP_PLACE, 32'd0, 1'b1, 32'hFFFF_FFFF, 20'hFFFFF));
    pending_orders.push_back(order_item(OP_FILL, 32'd1, 1'b0, 32'd0, 20'd0));
    pending_orders.push_back(order_item(OP_LOOKUP, 32'd1, 1'b0, 32'd0, 20'd0));
    pending_orders.push_back(order_item(OP_FILL, 32'd1, 1'b1, 32'hFFFF_FFFF, 20'd5));
    pending_orders.push_back(order_item(OP_FILL, 32'd1, 1'b0, 32'd0, 20'hFFFFF));
    pending_orders.push_back(order_item(OP_PLACE, 32'd7, 1'b0, 32'd1234, 20'd10));
    pending_orders.push_back(order_item(OP_CANCEL, 32'd2, 1'b0, 32'd0, 20'd0));
    pending_orders.push_back(order_item(OP_CANCEL, 32'd2, 1'b0, 32'd0, 20'd0));
    pending_orders.push_back(order_item(OP_PLACE, 32'd0, 1'b1, 32'h8000_0000, 20'd7));
    pending_orders.push_back(order_item(OP_FILL, 32'd259, 1'b0, 32'd0, 20'd7));
    pending_orders.push_back(order_item(OP_FILL, 32'hFFFF_FFFF, 1'b0, 32'd0, 20'd1));
    pending_orders.push_back(order_item(OP_LOOKUP, 32'd3, 1'b0, 32'd0, 20'd0));
    pending_orders.push_back(order_item(OP_FILL, 32'd3, 1'b0, 32'd0, 20'd3));
    pending_orders.push_back(order_item(OP_CANCEL, 32'd3, 1'b0, 32'd0, 20'd0));
    pending_orders.push_back(order_item(OP_PLACE, 32'd0, 1'b0, 32'd99, 20'd1));
    pending_orders.push_back(order_item(OP_FILL, 32'd4, 1'b1, 32'd0, 20'd1));
    wait_until_drained();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      // Stall the receiver while the sender keeps pushing, to back up the pipeline.
      if (ph == 4 || ph == 8) hold_requests = hold_requests + 1;
      queue_random_batch(BATCH_ITEMS, ph % 3 == 1);
      wait_until_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("tb: %0d results checked: %0d place, %0d cancel, %0d fill, %0d lookup",
             checked, op_count[0], op_count[1], op_count[2], op_count[3]);
    $display("tb: outcomes %0d ok, %0d not found, %0d table full; %0d mismatches",
             err_count[0], err_count[1], err_count[2], errors);
    if (errors == 0 && expected_rsp.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/olt_pkg.sv
src/olt_slot_ram.sv
src/olt_exec.sv
src/order_lifecycle_table_top.sv
tb/sv/tb_top.sv
